### rtl/core/lfmn_pkg.sv
// ----------------------------------------------------------------------------
// lfmn_pkg
// Types and constants shared by the marker navigator modules: item payloads,
// configuration register set, navigation state and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfmn_pkg;

	typedef struct packed {
		logic        far_left_seen;
		logic        left_seen;
		logic        center_seen;
		logic        right_seen;
		logic        far_right_seen;
		logic [31:0] now_seconds;
	} nav_in_t;

	typedef struct packed {
		logic signed [7:0] left_speed;
		logic signed [7:0] right_speed;
		logic              led_on;
		logic              run_finished;
		logic              edge_followed;
		logic              update_urgent;
	} nav_out_t;

	typedef struct packed {
		logic       long_route;
		logic [6:0] full_speed;
		logic [7:0] min_delay_s;
		logic [7:0] first_timeout_s;
		logic [7:0] second_timeout_s;
	} nav_cfg_t;

	// Navigation state except the marker time stamp, whose width is a parameter.
	typedef struct packed {
		logic       edge_right;
		logic [1:0] crossings;
		logic       done;
	} nav_state_t;

	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_ROUTE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FULL_SPEED     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DELAY      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_TIMEOUT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_TIMEOUT = 3'd4;

	localparam logic [6:0] RST_FULL_SPEED     = 7'd20;
	localparam logic [7:0] RST_MIN_DELAY      = 8'd1;
	localparam logic [7:0] RST_FIRST_TIMEOUT  = 8'd5;
	localparam logic [7:0] RST_SECOND_TIMEOUT = 8'd20;

	localparam logic [1:0] CROSSINGS_ARMED = 2'd2;
	localparam logic [1:0] CROSSINGS_NONE  = 2'd0;

	// x / 3 for any 7-bit x equals (x * 171) >> 9.
	localparam int unsigned THIRD_MUL   = 171;
	localparam int unsigned THIRD_SHIFT = 9;

endpackage

`default_nettype wire

### rtl/core/lfmn_marker.sv
// ----------------------------------------------------------------------------
// lfmn_marker
// Next-state logic for one tick: finish latch, crossing timeouts, marker
// detection that picks the followed edge, and crossing bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module lfmn_marker #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire lfmn_pkg::nav_cfg_t   cfg,
	input  wire lfmn_pkg::nav_state_t cur,
	input  wire [TIME_BITS-1:0]       marker_cur,
	input  wire [TIME_BITS-1:0]       now,
	input  wire                       fl,
	input  wire                       fr,
	input  wire                       fl_rise,
	input  wire                       fr_rise,
	output lfmn_pkg::nav_state_t      nxt,
	output logic [TIME_BITS-1:0]      marker_nxt
);

	logic [TIME_BITS-1:0] diff;
	logic                 too_early;
	logic [1:0]           cr_a;
	logic [1:0]           cr_b;

	assign diff = now - marker_cur;
	assign too_early = diff[TIME_BITS-1] || (diff < TIME_BITS'(cfg.min_delay_s));

	always_comb begin
		nxt = cur;
		marker_nxt = marker_cur;
		cr_a = cur.crossings;
		cr_b = cur.crossings;
		if (!cur.done) begin
			nxt.done = fl && fr;
			if (!too_early) begin
				if (cur.crossings == lfmn_pkg::CROSSINGS_ARMED &&
						diff >= TIME_BITS'(cfg.first_timeout_s)) begin
					cr_a = lfmn_pkg::CROSSINGS_NONE;
				end
				cr_b = cr_a;
				if (cr_a != lfmn_pkg::CROSSINGS_NONE &&
						diff >= TIME_BITS'(cfg.second_timeout_s)) begin
					cr_b = lfmn_pkg::CROSSINGS_NONE;
				end
				nxt.crossings = cr_b;
				if (cr_b == lfmn_pkg::CROSSINGS_NONE) begin
					// Far left wins when both far sensors see a marker.
					if (fl) begin
						nxt.edge_right = cfg.long_route;
						nxt.crossings = lfmn_pkg::CROSSINGS_ARMED;
						marker_nxt = now;
					end else if (fr) begin
						nxt.edge_right = !cfg.long_route;
						nxt.crossings = lfmn_pkg::CROSSINGS_ARMED;
						marker_nxt = now;
					end
				end else if ((fr_rise && !cur.edge_right) || (fl_rise && cur.edge_right)) begin
					nxt.crossings = cr_b - 2'd1;
					marker_nxt = now;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/lfmn_drive.sv
// ----------------------------------------------------------------------------
// lfmn_drive
// Wheel speed selection: straight at full speed, or a turn with the inside
// wheel reversed at a third of full speed; zero once finished.
// ----------------------------------------------------------------------------
`default_nettype none

module lfmn_drive (
	input  wire [6:0]         full_speed,
	input  wire               stopped,
	input  wire               edge_right,
	input  wire               left_seen,
	input  wire               center_seen,
	input  wire               right_seen,
	output logic signed [7:0] left_speed,
	output logic signed [7:0] right_speed
);

	logic [15:0]       prod;
	logic [6:0]        third;
	logic signed [7:0] full;
	logic signed [7:0] back;

	assign prod = 16'(full_speed) * 16'(lfmn_pkg::THIRD_MUL);
	assign third = prod[lfmn_pkg::THIRD_SHIFT +: 7];
	assign full = {1'b0, full_speed};
	assign back = 8'sd0 - $signed({1'b0, third});

	always_comb begin
		left_speed = 8'sd0;
		right_speed = 8'sd0;
		if (!stopped) begin
			if (!edge_right) begin
				if (left_seen) begin
					left_speed = back;
					right_speed = full;
				end else if (!center_seen) begin
					left_speed = full;
					right_speed = back;
				end else begin
					left_speed = full;
					right_speed = full;
				end
			end else begin
				if (right_seen) begin
					left_speed = full;
					right_speed = back;
				end else if (!center_seen) begin
					left_speed = back;
					right_speed = full;
				end else begin
					left_speed = full;
					right_speed = full;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/line_follower_marker_navigator_unit.sv
// Throughput: one tick per cycle while results are taken; an accepted tick
// waits in the input register, which feeds the marker and drive logic, and
// that logic writes the result register and the navigation state.
// A full result register that is not taken holds back the input register.
// Reset clears the navigation state, the valid flags and loads the register
// defaults (shorter path, full speed 20, delays 1, 5 and 20 seconds).
// ----------------------------------------------------------------------------
// line_follower_marker_navigator_unit
// Top level: handshakes, configuration registers, navigation state and
// result register of the line follower marker navigator.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_marker_navigator_unit #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire lfmn_pkg::nav_in_t                in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output lfmn_pkg::nav_out_t                    out_data,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [lfmn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire [lfmn_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	lfmn_pkg::nav_cfg_t   cfg_q;
	lfmn_pkg::nav_state_t st_q;
	lfmn_pkg::nav_state_t st_nxt;
	logic [TIME_BITS-1:0] marker_q;
	logic [TIME_BITS-1:0] marker_nxt;
	logic [3:0]           prev_q;

	lfmn_pkg::nav_in_t    in_s1;
	logic                 vld_s1;
	lfmn_pkg::nav_out_t   out_q;
	logic                 out_vld_q;

	logic                 advance;
	logic [TIME_BITS-1:0] now;
	logic                 fl_rise;
	logic                 fr_rise;
	logic                 urgent;
	logic signed [7:0]    ls;
	logic signed [7:0]    rs;

	assign cfg_ready = 1'b1;
	assign advance = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;
	assign out_valid = out_vld_q;
	assign out_data = out_q;

	assign now = TIME_BITS'(in_s1.now_seconds);
	// Previous bits: [0] far left, [1] left, [2] right, [3] far right.
	assign fl_rise = in_s1.far_left_seen && !prev_q[0];
	assign fr_rise = in_s1.far_right_seen && !prev_q[3];
	assign urgent = (in_s1.far_left_seen && in_s1.far_right_seen) || fl_rise || fr_rise ||
		(in_s1.left_seen != prev_q[1]) || (in_s1.right_seen != prev_q[2]);

	lfmn_marker #(
		.TIME_BITS(TIME_BITS)
	) u_marker (
		.cfg       (cfg_q),
		.cur       (st_q),
		.marker_cur(marker_q),
		.now       (now),
		.fl        (in_s1.far_left_seen),
		.fr        (in_s1.far_right_seen),
		.fl_rise   (fl_rise),
		.fr_rise   (fr_rise),
		.nxt       (st_nxt),
		.marker_nxt(marker_nxt)
	);

	lfmn_drive u_drive (
		.full_speed (cfg_q.full_speed),
		.stopped    (st_q.done),
		.edge_right (st_nxt.edge_right),
		.left_seen  (in_s1.left_seen),
		.center_seen(in_s1.center_seen),
		.right_seen (in_s1.right_seen),
		.left_speed (ls),
		.right_speed(rs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_route <= 1'b0;
			cfg_q.full_speed <= lfmn_pkg::RST_FULL_SPEED;
			cfg_q.min_delay_s <= lfmn_pkg::RST_MIN_DELAY;
			cfg_q.first_timeout_s <= lfmn_pkg::RST_FIRST_TIMEOUT;
			cfg_q.second_timeout_s <= lfmn_pkg::RST_SECOND_TIMEOUT;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfmn_pkg::REG_LONG_ROUTE:     cfg_q.long_route <= cfg_data[0];
				lfmn_pkg::REG_FULL_SPEED:     cfg_q.full_speed <= cfg_data[6:0];
				lfmn_pkg::REG_MIN_DELAY:      cfg_q.min_delay_s <= cfg_data;
				lfmn_pkg::REG_FIRST_TIMEOUT:  cfg_q.first_timeout_s <= cfg_data;
				lfmn_pkg::REG_SECOND_TIMEOUT: cfg_q.second_timeout_s <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			st_q <= '0;
			marker_q <= '0;
			prev_q <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
				st_q <= st_nxt;
				marker_q <= marker_nxt;
				prev_q <= {in_s1.far_right_seen, in_s1.right_seen, in_s1.left_seen,
					in_s1.far_left_seen};
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (advance) begin
			out_q.left_speed <= ls;
			out_q.right_speed <= rs;
			out_q.led_on <= (st_q.crossings == lfmn_pkg::CROSSINGS_NONE);
			out_q.run_finished <= st_nxt.done;
			out_q.edge_followed <= st_nxt.edge_right;
			out_q.update_urgent <= urgent;
		end
	end

	a_crossings_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.crossings != 2'd3)
		else $error("crossing count out of range");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(st_q.done))
		else $error("finish latch cleared without reset");

	a_stopped_speeds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && st_q.done |=> out_q.left_speed == 8'sd0 && out_q.right_speed == 8'sd0)
		else $error("wheels driven after finish");

	a_rearm_only_to_two: assert property (@(posedge clk) disable iff (!arst_n)
		advance && st_nxt.crossings > st_q.crossings |-> st_nxt.crossings ==
		lfmn_pkg::CROSSINGS_ARMED)
		else $error("crossing count rose to a value other than armed");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_vld_q)
		else $error("result lost after advance");

endmodule

`default_nettype wire

### dv/line_follower_marker_navigator_checker.sv
// ----------------------------------------------------------------------------
// Line follower marker navigator checker
// Watches the tick, result and register channels of the navigator. It keeps
// its own copy of the registers and the navigation state, predicts the result
// of every accepted tick and compares each returned result, field by field,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module line_follower_marker_navigator_checker (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	input  wire                                in_ready,
	input  wire lfmn_pkg::nav_in_t             in_data,
	input  wire                                out_valid,
	input  wire                                out_ready,
	input  wire lfmn_pkg::nav_out_t            out_data,
	input  wire                                cfg_valid,
	input  wire                                cfg_ready,
	input  wire [lfmn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire [lfmn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 mismatches,
	output int                                 results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import lfmn_pkg::*;

	localparam logic [7:0] SPEED_DIVISOR = 8'd3;

	nav_cfg_t    regs;
	logic        edge_right;
	logic [1:0]  crossings;
	logic [31:0] marker_s;
	logic        finished;
	logic        was_far_left;
	logic        was_left;
	logic        was_right;
	logic        was_far_right;
	nav_out_t    drive_queue[$];
	int          result_no;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Advances the navigation state by one tick and returns the result it causes.
	function automatic nav_out_t next_drive(input nav_in_t t);
		logic        fl_rise;
		logic        fr_rise;
		logic [31:0] since_marker;
		logic [7:0]  fast;
		logic [7:0]  slow;
		nav_out_t    r;
		fl_rise = t.far_left_seen && !was_far_left;
		fr_rise = t.far_right_seen && !was_far_right;
		fast = {1'b0, regs.full_speed};
		slow = 8'd0 - fast / SPEED_DIVISOR;
		r = '0;
		r.led_on = (crossings == CROSSINGS_NONE);
		r.update_urgent = (t.far_left_seen && t.far_right_seen) || fl_rise || fr_rise ||
			(t.left_seen != was_left) || (t.right_seen != was_right);
		if (!finished) begin
			finished = t.far_left_seen && t.far_right_seen;
			since_marker = t.now_seconds - marker_s;
			// A time stamp behind the last marker reads as negative and counts as too early.
			if (!since_marker[31] && since_marker >= regs.min_delay_s) begin
				if (crossings == CROSSINGS_ARMED && since_marker >= regs.first_timeout_s)
					crossings = CROSSINGS_NONE;
				if (crossings != CROSSINGS_NONE && since_marker >= regs.second_timeout_s)
					crossings = CROSSINGS_NONE;
				if (crossings == CROSSINGS_NONE) begin
					// The far-left rule is applied last so that it wins when both are on.
					if (t.far_right_seen) begin
						edge_right = !regs.long_route;
						crossings = CROSSINGS_ARMED;
						marker_s = t.now_seconds;
					end
					if (t.far_left_seen) begin
						edge_right = regs.long_route;
						crossings = CROSSINGS_ARMED;
						marker_s = t.now_seconds;
					end
				end else begin
					if (fr_rise && !edge_right) begin
						crossings = crossings - 2'd1;
						marker_s = t.now_seconds;
					end
					if (fl_rise && edge_right) begin
						crossings = crossings - 2'd1;
						marker_s = t.now_seconds;
					end
				end
			end
			if (!edge_right) begin
				if (t.left_seen) begin
					r.left_speed = slow;
					r.right_speed = fast;
				end else if (!t.center_seen) begin
					r.left_speed = fast;
					r.right_speed = slow;
				end else begin
					r.left_speed = fast;
					r.right_speed = fast;
				end
			end else begin
				if (t.right_seen) begin
					r.left_speed = fast;
					r.right_speed = slow;
				end else if (!t.center_seen) begin
					r.left_speed = slow;
					r.right_speed = fast;
				end else begin
					r.left_speed = fast;
					r.right_speed = fast;
				end
			end
		end
		was_far_left = t.far_left_seen;
		was_left = t.left_seen;
		was_right = t.right_seen;
		was_far_right = t.far_right_seen;
		r.run_finished = finished;
		r.edge_followed = edge_right;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nav_out_t want;
		if (!arst_n) begin
			regs = '{1'b0, RST_FULL_SPEED, RST_MIN_DELAY, RST_FIRST_TIMEOUT,
				RST_SECOND_TIMEOUT};
			edge_right = 1'b0;
			crossings = CROSSINGS_NONE;
			marker_s = '0;
			finished = 1'b0;
			was_far_left = 1'b0;
			was_left = 1'b0;
			was_right = 1'b0;
			was_far_right = 1'b0;
			drive_queue.delete();
			result_no = 0;
			mismatches = 0;
		end else begin
			// A result leaves only after its tick has passed the input register and the
			// result register, so the oldest prediction is taken before this edge's tick is added.
			if (out_valid && out_ready) begin
				if (drive_queue.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no tick outstanding",
						result_no));
				end else begin
					want = drive_queue.pop_front();
					if (out_data.left_speed !== want.left_speed)
						report_mismatch($sformatf("result %0d left_speed %0d, expected %0d",
							result_no, out_data.left_speed, want.left_speed));
					if (out_data.right_speed !== want.right_speed)
						report_mismatch($sformatf("result %0d right_speed %0d, expected %0d",
							result_no, out_data.right_speed, want.right_speed));
					if (out_data.led_on !== want.led_on)
						report_mismatch($sformatf("result %0d led_on %b, expected %b",
							result_no, out_data.led_on, want.led_on));
					if (out_data.run_finished !== want.run_finished)
						report_mismatch($sformatf("result %0d run_finished %b, expected %b",
							result_no, out_data.run_finished, want.run_finished));
					if (out_data.edge_followed !== want.edge_followed)
						report_mismatch($sformatf("result %0d edge_followed %b, expected %b",
							result_no, out_data.edge_followed, want.edge_followed));
					if (out_data.update_urgent !== want.update_urgent)
						report_mismatch($sformatf("result %0d update_urgent %b, expected %b",
							result_no, out_data.update_urgent, want.update_urgent));
				end
				result_no++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LONG_ROUTE:     regs.long_route = cfg_data[0];
					REG_FULL_SPEED:     regs.full_speed = cfg_data[6:0];
					REG_MIN_DELAY:      regs.min_delay_s = cfg_data;
					REG_FIRST_TIMEOUT:  regs.first_timeout_s = cfg_data;
					REG_SECOND_TIMEOUT: regs.second_timeout_s = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				drive_queue.push_back(next_drive(in_data));
		end
		results_owed = drive_queue.size();
	end

endmodule

### dv/tb_line_follower_marker_navigator_unit.sv
// ----------------------------------------------------------------------------
// Line follower marker navigator testbench
// Drives navigation ticks and register writes into the navigator with random
// gaps and result back-pressure. A directed run of marker, crossing, timeout
// and time-wrap ticks is followed by several register settings with random
// sensor sequences, and the run ends with the finish condition.
// ----------------------------------------------------------------------------
module tb_line_follower_marker_navigator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lfmn_pkg::*;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	nav_in_t                  in_data = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	nav_out_t                 out_data;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int                       mismatches;
	int                       results_owed;

	// While set, neither side idles.
	logic                     steady = 1'b0;
	logic [31:0]              clock_s = '0;

	line_follower_marker_navigator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	line_follower_marker_navigator_checker nav_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 8);
	end

	function automatic nav_in_t sensors_at(input logic fl, input logic l, input logic c,
		input logic r, input logic fr, input logic [31:0] now);
		nav_in_t t;
		t = '{fl, l, c, r, fr, now};
		return t;
	endfunction

	// Mostly a running clock with single far-side markers; some time jumps,
	// small steps back, one-off random time stamps and sensor noise.
	function automatic nav_in_t random_tick();
		nav_in_t t;
		int      roll;
		roll = $urandom_range(0, 99);
		t = '0;
		t.left_seen = 1'($urandom_range(0, 1));
		t.center_seen = 1'($urandom_range(0, 1));
		t.right_seen = 1'($urandom_range(0, 1));
		if (roll < 85) begin
			if (roll < 70)
				clock_s = clock_s + $urandom_range(0, 3);
			else if ($urandom_range(0, 1))
				clock_s = clock_s + $urandom_range(4, 30);
			else
				clock_s = clock_s + $urandom_range(31, 300);
			if ($urandom_range(0, 99) < 18) begin
				if ($urandom_range(0, 1))
					t.far_left_seen = 1'b1;
				else
					t.far_right_seen = 1'b1;
			end
		end else if (roll < 90) begin
			clock_s = clock_s - $urandom_range(1, 100);
		end else if (roll < 94) begin
			t.now_seconds = $urandom;
			return t;
		end else begin
			t.far_left_seen = 1'($urandom_range(0, 1));
			t.far_right_seen = !t.far_left_seen && $urandom_range(0, 1);
		end
		t.now_seconds = clock_s;
		return t;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so back-to-back ticks are sent without a gap.
	task automatic send_tick(input nav_in_t t);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 8) ? 1 : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
	endtask

	task automatic set_phase(input int phase);
		case (phase)
			0: begin
				write_reg(REG_LONG_ROUTE, 8'd1);
				write_reg(REG_FULL_SPEED, 8'd127);
				write_reg(REG_MIN_DELAY, 8'd0);
				write_reg(REG_FIRST_TIMEOUT, 8'd0);
				write_reg(REG_SECOND_TIMEOUT, 8'd0);
			end
			1: begin
				write_reg(REG_LONG_ROUTE, 8'd0);
				write_reg(REG_FULL_SPEED, 8'd0);
				write_reg(REG_MIN_DELAY, 8'd255);
				write_reg(REG_FIRST_TIMEOUT, 8'd255);
				write_reg(REG_SECOND_TIMEOUT, 8'd255);
			end
			2: begin
				write_reg(REG_LONG_ROUTE, 8'd1);
				write_reg(REG_FULL_SPEED, 8'($urandom_range(1, 126)));
				write_reg(REG_MIN_DELAY, 8'd1);
				write_reg(REG_FIRST_TIMEOUT, 8'd3);
				write_reg(REG_SECOND_TIMEOUT, 8'd10);
			end
			3: begin
				// Bits above each register's width must be dropped, and writes
				// past the last register must change nothing.
				write_reg(REG_LONG_ROUTE, 8'hFE);
				write_reg(REG_FULL_SPEED, 8'hFF);
				write_reg(REG_MIN_DELAY, 8'd2);
				write_reg(REG_FIRST_TIMEOUT, 8'd6);
				write_reg(REG_SECOND_TIMEOUT, 8'd12);
				for (int i = int'(REG_SECOND_TIMEOUT) + 1; i < (1 << CFG_IDX_BITS); i++)
					write_reg(CFG_IDX_BITS'(i), 8'($urandom));
			end
			4: begin
				write_reg(REG_LONG_ROUTE, 8'($urandom));
				write_reg(REG_FULL_SPEED, 8'($urandom));
				write_reg(REG_MIN_DELAY, 8'($urandom_range(0, 3)));
				write_reg(REG_FIRST_TIMEOUT, 8'($urandom_range(0, 30)));
				write_reg(REG_SECOND_TIMEOUT, 8'($urandom_range(0, 60)));
			end
			default: begin
				write_reg(REG_LONG_ROUTE, 8'd0);
				write_reg(REG_FULL_SPEED, 8'd45);
				write_reg(REG_MIN_DELAY, 8'd0);
				write_reg(REG_FIRST_TIMEOUT, 8'd2);
				write_reg(REG_SECOND_TIMEOUT, 8'd255);
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: drive patterns, a right marker with its crossings,
		// a left marker, both timeouts, time stamps behind the marker and a
		// marker just before the time stamp wraps.
		send_tick(sensors_at(0, 0, 0, 0, 0, 32'd0));
		send_tick(sensors_at(0, 0, 1, 0, 0, 32'd1));
		send_tick(sensors_at(0, 1, 1, 0, 0, 32'd2));
		send_tick(sensors_at(0, 0, 1, 1, 0, 32'd3));
		send_tick(sensors_at(0, 0, 0, 0, 1, 32'd5));
		send_tick(sensors_at(0, 0, 1, 0, 0, 32'd6));
		send_tick(sensors_at(1, 0, 1, 0, 0, 32'd7));
		send_tick(sensors_at(0, 1, 0, 1, 0, 32'd8));
		send_tick(sensors_at(1, 0, 1, 0, 0, 32'd9));
		send_tick(sensors_at(0, 1, 1, 1, 0, 32'd10));
		send_tick(sensors_at(1, 0, 0, 0, 0, 32'd12));
		send_tick(sensors_at(0, 0, 1, 0, 1, 32'd14));
		send_tick(sensors_at(0, 0, 1, 0, 0, 32'd40));
		send_tick(sensors_at(0, 0, 0, 0, 1, 32'd41));
		send_tick(sensors_at(0, 0, 1, 0, 0, 32'd46));
		send_tick(sensors_at(1, 0, 0, 0, 0, 32'd30));
		send_tick(sensors_at(0, 1, 1, 1, 0, 32'hFFFF_FFFF));
		send_tick(sensors_at(0, 0, 0, 0, 1, 32'h8000_0000));
		send_tick(sensors_at(0, 0, 1, 0, 0, 32'h7FFF_FFFF));
		send_tick(sensors_at(1, 1, 1, 1, 0, 32'h0000_0010));
		send_tick(sensors_at(0, 0, 0, 0, 1, 32'hAAAA_AAAA));
		send_tick(sensors_at(1, 0, 0, 0, 0, 32'h5555_5555));
		send_tick(sensors_at(0, 1, 0, 0, 0, 32'h5555_5556));
		send_tick(sensors_at(0, 0, 0, 0, 1, 32'hC000_0000));
		send_tick(sensors_at(1, 0, 1, 0, 0, 32'hFFFF_FFF0));
		clock_s = 32'hFFFF_FFF2;

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			set_phase(phase);
			steady = (phase == 3);
			repeat (110) send_tick(random_tick());
		end
		steady = 1'b0;

		// Clear anything pending, then finish with both far sensors on; the
		// ticks after that must keep both wheels stopped.
		clock_s = clock_s + 32'd300;
		send_tick(sensors_at(0, 0, 1, 0, 0, clock_s));
		clock_s = clock_s + 32'd1;
		send_tick(sensors_at(1, 1, 1, 1, 1, clock_s));
		repeat (15) begin
			clock_s = clock_s + $urandom_range(0, 300);
			send_tick(sensors_at(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), clock_s));
		end

		drain();
		repeat (4) @(negedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
